FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/stni_pkg.sv
// ----------------------------------------------------------------------------
// stni_pkg
// Types, constants and node offset tables of the triangle node indexer.
// ----------------------------------------------------------------------------
package stni_pkg;

  // largest usable cell count, larger register values are clamped
  localparam int MAX_CELLS = 1024;

  localparam int CELL_W  = 10;           // cell column / row
  localparam int CNT_W   = 11;           // cell count registers
  localparam int FINE_W  = CNT_W + 2;    // fine coordinate and fine width
  localparam int PROD_W  = 2 * FINE_W;   // fine row times fine width
  localparam int NODE_W  = 25;
  localparam int SLOT_W  = 4;
  localparam int OFF_W   = 3;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_ACROSS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_DOWN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_ORDER = 2'd2;

  // element order codes
  localparam logic ORDER_QUAD  = 1'b0;
  localparam logic ORDER_QUART = 1'b1;

  // final local slot of a triangle
  localparam logic [SLOT_W-1:0] QUAD_LAST_SLOT  = 4'd5;
  localparam logic [SLOT_W-1:0] QUART_LAST_SLOT = 4'd14;

  typedef struct packed {
    logic [CELL_W-1:0] cell_col;
    logic [CELL_W-1:0] cell_row;
  } in_word_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic              upper_half;
    logic [SLOT_W-1:0] local_slot;
    logic              error;
    logic              last;
  } out_word_t;

  // one node request from the sequencer to the datapath
  typedef struct packed {
    logic [CELL_W-1:0] col;
    logic [CELL_W-1:0] row;
    logic              upper;
    logic [SLOT_W-1:0] slot;
    logic              err;
    logic              last;
  } tok_t;

  // grid geometry seen by the datapath
  typedef struct packed {
    logic              order;
    logic [FINE_W-1:0] fine_width;
  } geom_t;

  // node offset inside the cell, in fine steps
  typedef struct packed {
    logic [OFF_W-1:0] a;
    logic [OFF_W-1:0] b;
  } offs_t;

  // quadratic offsets, half-cell units
  function automatic offs_t quad_off(input logic upper, input logic [SLOT_W-1:0] slot);
    offs_t o;
    o = '{a: 3'd0, b: 3'd0};
    case ({upper, slot})
      5'h00: o = '{a: 3'd0, b: 3'd0};
      5'h01: o = '{a: 3'd2, b: 3'd0};
      5'h02: o = '{a: 3'd0, b: 3'd2};
      5'h03: o = '{a: 3'd1, b: 3'd0};
      5'h04: o = '{a: 3'd1, b: 3'd1};
      5'h05: o = '{a: 3'd0, b: 3'd1};
      5'h10: o = '{a: 3'd2, b: 3'd0};
      5'h11: o = '{a: 3'd2, b: 3'd2};
      5'h12: o = '{a: 3'd0, b: 3'd2};
      5'h13: o = '{a: 3'd2, b: 3'd1};
      5'h14: o = '{a: 3'd1, b: 3'd2};
      5'h15: o = '{a: 3'd1, b: 3'd1};
      default: o = '{a: 3'd0, b: 3'd0};
    endcase
    return o;
  endfunction

  // quartic offsets, quarter-cell units
  function automatic offs_t quart_off(input logic upper, input logic [SLOT_W-1:0] slot);
    offs_t o;
    o = '{a: 3'd0, b: 3'd0};
    case ({upper, slot})
      5'h00: o = '{a: 3'd0, b: 3'd0};
      5'h01: o = '{a: 3'd4, b: 3'd0};
      5'h02: o = '{a: 3'd0, b: 3'd4};
      5'h03: o = '{a: 3'd1, b: 3'd0};
      5'h04: o = '{a: 3'd2, b: 3'd0};
      5'h05: o = '{a: 3'd3, b: 3'd0};
      5'h06: o = '{a: 3'd3, b: 3'd1};
      5'h07: o = '{a: 3'd2, b: 3'd2};
      5'h08: o = '{a: 3'd1, b: 3'd3};
      5'h09: o = '{a: 3'd0, b: 3'd3};
      5'h0a: o = '{a: 3'd0, b: 3'd2};
      5'h0b: o = '{a: 3'd0, b: 3'd1};
      5'h0c: o = '{a: 3'd1, b: 3'd1};
      5'h0d: o = '{a: 3'd2, b: 3'd1};
      5'h0e: o = '{a: 3'd1, b: 3'd2};
      5'h10: o = '{a: 3'd4, b: 3'd0};
      5'h11: o = '{a: 3'd4, b: 3'd4};
      5'h12: o = '{a: 3'd0, b: 3'd4};
      5'h13: o = '{a: 3'd4, b: 3'd1};
      5'h14: o = '{a: 3'd4, b: 3'd2};
      5'h15: o = '{a: 3'd4, b: 3'd3};
      5'h16: o = '{a: 3'd3, b: 3'd4};
      5'h17: o = '{a: 3'd2, b: 3'd4};
      5'h18: o = '{a: 3'd1, b: 3'd4};
      5'h19: o = '{a: 3'd1, b: 3'd3};
      5'h1a: o = '{a: 3'd2, b: 3'd2};
      5'h1b: o = '{a: 3'd3, b: 3'd1};
      5'h1c: o = '{a: 3'd3, b: 3'd2};
      5'h1d: o = '{a: 3'd3, b: 3'd3};
      5'h1e: o = '{a: 3'd2, b: 3'd3};
      default: o = '{a: 3'd0, b: 3'd0};
    endcase
    return o;
  endfunction

endpackage

FILE: rtl/structured_triangle_node_indexer_top.sv
// ----------------------------------------------------------------------------
// structured_triangle_node_indexer_top
// Emits the global fine-grid node indices of the two triangles of a grid cell.
// ----------------------------------------------------------------------------
// Each accepted cell word produces 12 result words in quadratic mode, 30 in
// quartic mode, or a single error word when the cell is outside the grid, one
// result per cycle while the output is not stalled; the slot sequencer that
// walks the triangle nodes sets that figure. The next cell word is taken in the
// cycle the last node of the current one is issued, so a stream of cells runs
// with no gap. The index datapath is three register stages deep, behind the
// sequencer registers. The user must write registers through cfg_we only while
// idle; the block itself does not enforce this.
module structured_triangle_node_indexer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  stni_pkg::in_word_t            in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output stni_pkg::out_word_t           out_word,
  input  logic                          cfg_we,
  input  logic [stni_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stni_pkg::CNT_W-1:0]    cfg_wdata
);
  import stni_pkg::*;

  localparam logic [FINE_W-1:0] MAX_CELLS_F = FINE_W'(MAX_CELLS);

  // configuration registers
  logic [CNT_W-1:0] cells_across_r;
  logic [CNT_W-1:0] cells_down_r;
  logic             element_order_r;

  // clamped counts and geometry
  logic [CNT_W-1:0] nx;
  logic [CNT_W-1:0] ny;
  geom_t            geom;

  // slot sequencer
  logic              busy_r,  busy_nxt;
  logic [CELL_W-1:0] col_r,   col_nxt;
  logic [CELL_W-1:0] row_r,   row_nxt;
  logic              err_r,   err_nxt;
  logic              upper_r, upper_nxt;
  logic [SLOT_W-1:0] slot_r,  slot_nxt;
  logic [SLOT_W-1:0] last_slot;
  logic              seq_last;
  logic              adv;
  logic              in_fire;
  tok_t              tok;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_across_r  <= CNT_W'(1);
      cells_down_r    <= CNT_W'(1);
      element_order_r <= ORDER_QUAD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELLS_ACROSS:  cells_across_r  <= cfg_wdata;
        REG_CELLS_DOWN:    cells_down_r    <= cfg_wdata;
        REG_ELEMENT_ORDER: element_order_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clamp counts and derive the fine width
  always_comb begin
    nx = ({2'b00, cells_across_r} > MAX_CELLS_F) ? MAX_CELLS_F[CNT_W-1:0] : cells_across_r;
    ny = ({2'b00, cells_down_r} > MAX_CELLS_F) ? MAX_CELLS_F[CNT_W-1:0] : cells_down_r;
    geom.order = element_order_r;
    if (element_order_r == ORDER_QUART) begin
      geom.fine_width = {nx, 2'b00} + FINE_W'(1);
    end else begin
      geom.fine_width = {1'b0, nx, 1'b0} + FINE_W'(1);
    end
  end

  // handshake: the pipeline moves when the output register can take a word
  always_comb begin
    last_slot = (element_order_r == ORDER_QUART) ? QUART_LAST_SLOT : QUAD_LAST_SLOT;
    seq_last  = busy_r && (err_r || (upper_r && (slot_r == last_slot)));
    adv       = !out_valid || out_ready;
    in_ready  = adv && (!busy_r || seq_last);
    in_fire   = in_valid && in_ready;
  end

  // current node request
  always_comb begin
    tok.col   = col_r;
    tok.row   = row_r;
    tok.upper = upper_r;
    tok.slot  = slot_r;
    tok.err   = err_r;
    tok.last  = seq_last;
  end

  // sequencer next state
  always_comb begin
    busy_nxt  = busy_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    err_nxt   = err_r;
    upper_nxt = upper_r;
    slot_nxt  = slot_r;
    if (adv && busy_r) begin
      if (seq_last) begin
        busy_nxt = 1'b0;
      end else if (slot_r == last_slot) begin
        slot_nxt  = '0;
        upper_nxt = 1'b1;
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
      end
    end
    if (in_fire) begin
      busy_nxt  = 1'b1;
      col_nxt   = in_word.cell_col;
      row_nxt   = in_word.cell_row;
      err_nxt   = ({1'b0, in_word.cell_col} >= nx) || ({1'b0, in_word.cell_row} >= ny);
      upper_nxt = 1'b0;
      slot_nxt  = '0;
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      upper_r <= 1'b0;
      slot_r  <= '0;
      err_r   <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      upper_r <= upper_nxt;
      slot_r  <= slot_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
    row_r <= row_nxt;
  end

  // index datapath
  stni_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .tok_valid (busy_r),
    .tok       (tok),
    .geom      (geom),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

FILE: rtl/stni_datapath.sv
// ----------------------------------------------------------------------------
// stni_datapath
// Three-stage node index pipeline: fine coordinates, row multiply, column add.
// ----------------------------------------------------------------------------
module stni_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              tok_valid,
  input  stni_pkg::tok_t    tok,
  input  stni_pkg::geom_t   geom,
  output logic              out_valid,
  output stni_pkg::out_word_t out_word
);
  import stni_pkg::*;

  // stage 1: fine column and row
  logic              s1_valid_r;
  tok_t              s1_tok_r;
  logic [FINE_W-1:0] s1_fc_r;
  logic [FINE_W-1:0] s1_fr_r;
  logic [FINE_W-1:0] s1_fc_nxt;
  logic [FINE_W-1:0] s1_fr_nxt;
  offs_t             off;

  // stage 2: row product
  logic              s2_valid_r;
  tok_t              s2_tok_r;
  logic [FINE_W-1:0] s2_fc_r;
  logic [PROD_W-1:0] s2_prod_r;

  // stage 3: output register
  logic              s3_valid_r;
  out_word_t         s3_word_r;
  out_word_t         s3_word_nxt;
  logic [PROD_W-1:0] node_sum;

  // offset lookup and cell base scaled to the fine grid
  always_comb begin
    off = (geom.order == ORDER_QUART) ? quart_off(tok.upper, tok.slot)
                                      : quad_off(tok.upper, tok.slot);
    if (geom.order == ORDER_QUART) begin
      s1_fc_nxt = {1'b0, tok.col, 2'b00} + FINE_W'(off.a);
      s1_fr_nxt = {1'b0, tok.row, 2'b00} + FINE_W'(off.b);
    end else begin
      s1_fc_nxt = {2'b00, tok.col, 1'b0} + FINE_W'(off.a);
      s1_fr_nxt = {2'b00, tok.row, 1'b0} + FINE_W'(off.b);
    end
  end

  // final sum, error results carry zero fields
  always_comb begin
    node_sum                = s2_prod_r + PROD_W'(s2_fc_r);
    s3_word_nxt.node_index  = s2_tok_r.err ? '0 : node_sum[NODE_W-1:0];
    s3_word_nxt.upper_half  = s2_tok_r.err ? 1'b0 : s2_tok_r.upper;
    s3_word_nxt.local_slot  = s2_tok_r.err ? '0 : s2_tok_r.slot;
    s3_word_nxt.error       = s2_tok_r.err;
    s3_word_nxt.last        = s2_tok_r.last;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= tok_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // payload, all stages move together
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tok_r  <= tok;
      s1_fc_r   <= s1_fc_nxt;
      s1_fr_r   <= s1_fr_nxt;
      s2_tok_r  <= s1_tok_r;
      s2_fc_r   <= s1_fc_r;
      s2_prod_r <= PROD_W'(s1_fr_r) * PROD_W'(geom.fine_width);
      s3_word_r <= s3_word_nxt;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_word  = s3_word_r;

endmodule

FILE: rtl/stni_checker.sv
// ----------------------------------------------------------------------------
// stni_checker
// Port-level checks of the triangle node indexer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stni_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input stni_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_ready,
  input stni_pkg::out_word_t out_word
);
  import stni_pkg::*;

  // a stalled result word holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))

  // no new cell while the output is stalled
  `ASSERT_IMPLY(a_stall_blocks_in, clk, rst_n, out_valid && !out_ready, !in_ready)

  // an error word stands alone with zero fields
  `ASSERT_IMPLY(a_err_word, clk, rst_n, out_valid && out_word.error, out_word.last && (out_word.node_index == '0) && (out_word.local_slot == '0))

  // last only on the final slot of an upper triangle
  `ASSERT_IMPLY(a_last_slot, clk, rst_n, out_valid && out_word.last && !out_word.error, out_word.upper_half && ((out_word.local_slot == QUAD_LAST_SLOT) || (out_word.local_slot == QUART_LAST_SLOT)))

endmodule

bind structured_triangle_node_indexer_top stni_checker u_stni_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

FILE: dv/structured_triangle_node_indexer_top_tb.sv
// ----------------------------------------------------------------------------
// structured_triangle_node_indexer_top_tb
// Self-checking bench for the triangle node indexer. Cell words go in through
// a valid/ready sender with random gaps. A local predictor works out the node
// index words of both triangles, or the single error word, and a checker
// compares every result word field by field. Grid settings change between
// phases, including zero, clamped and full-size grids in both element orders.
// ----------------------------------------------------------------------------
module structured_triangle_node_indexer_top_tb;
  import stni_pkg::*;

  // index with no register behind it, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_word;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_wdata = '0;

  // local copy of the grid registers, reset values
  logic [CNT_W-1:0] grid_across = 11'd1;
  logic [CNT_W-1:0] grid_down = 11'd1;
  logic             grid_order = ORDER_QUAD;

  out_word_t expected_nodes[$];
  int        error_count = 0;
  bit        tx_gaps_on = 1'b1;
  bit        rx_stalls_on = 1'b1;
  int        hold_off_cycles = 0;

  structured_triangle_node_indexer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    error_count++;
  endtask

  // append one word to the expected list
  task automatic queue_expected(input out_word_t r);
    expected_nodes = {expected_nodes, r};
  endtask

  // fine offset (a, b) of a local node, walking corners, then the triangle
  // edges, then the quartic interior points
  function automatic void node_offset(input bit upper, input int slot, input int s,
                                      output int a, output int b);
    int edge_len, side, k, m;
    edge_len = s - 1;
    side = (slot - 3) / edge_len;
    k = (slot - 3) % edge_len + 1;
    m = slot - 3 - 3 * edge_len;
    if (slot < 3) begin
      if (!upper) begin
        a = (slot == 1) ? s : 0;
        b = (slot == 2) ? s : 0;
      end else begin
        a = (slot == 2) ? 0 : s;
        b = (slot == 0) ? 0 : s;
      end
    end else if (side < 3) begin
      case (side)
        0: begin
          a = upper ? s : k;
          b = upper ? k : 0;
        end
        1: begin
          a = s - k;
          b = upper ? s : k;
        end
        default: begin
          a = upper ? k : 0;
          b = s - k;
        end
      endcase
    end else if (!upper) begin
      a = (m == 1) ? 2 : 1;
      b = (m == 2) ? 2 : 1;
    end else begin
      a = (m == 2) ? 2 : 3;
      b = (m == 0) ? 2 : 3;
    end
  endfunction

  // expected result words of one cell word
  task automatic predict_nodes(input in_word_t cw);
    int nx, ny, s, per, a, b, half, n;
    longint fine_w, node;
    out_word_t r;
    nx = (grid_across > MAX_CELLS) ? MAX_CELLS : int'(grid_across);
    ny = (grid_down > MAX_CELLS) ? MAX_CELLS : int'(grid_down);
    s = (grid_order == ORDER_QUART) ? 4 : 2;
    per = (grid_order == ORDER_QUART) ? 15 : 6;
    if (int'(cw.cell_col) >= nx || int'(cw.cell_row) >= ny) begin
      r = '0;
      r.error = 1'b1;
      r.last = 1'b1;
      queue_expected(r);
    end else begin
      fine_w = s * nx + 1;
      for (half = 0; half < 2; half++) begin
        for (n = 0; n < per; n++) begin
          node_offset(half[0], n, s, a, b);
          node = longint'(s * int'(cw.cell_row) + b) * fine_w
               + s * int'(cw.cell_col) + a;
          r.node_index = node[NODE_W-1:0];
          r.upper_half = half[0];
          r.local_slot = n[SLOT_W-1:0];
          r.error = 1'b0;
          r.last = (half == 1) && (n == per - 1);
          queue_expected(r);
        end
      end
    end
  endtask

  // one register write, local copy follows at the same edge
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_CELLS_ACROSS: grid_across = val;
      REG_CELLS_DOWN: grid_down = val;
      REG_ELEMENT_ORDER: grid_order = val[0];
      default: ;
    endcase
  endtask

  // only called with the block idle
  task automatic program_grid(input logic [CNT_W-1:0] across, input logic [CNT_W-1:0] down,
                              input logic order);
    cfg_write(REG_CELLS_ACROSS, across);
    cfg_write(REG_CELLS_DOWN, down);
    cfg_write(REG_ELEMENT_ORDER, {10'($urandom_range(0, 1023)), order});
    cfg_write(REG_UNUSED, 11'($urandom_range(0, 2047)));
    cfg_we <= 1'b0;
  endtask

  // send one cell word, optionally after a gap, and predict on accept
  task automatic offer_cell(input in_word_t cw);
    int gap;
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= cw;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predict_nodes(cw);
  endtask

  // drop valid, let every expected word arrive, then cover the pipeline
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (expected_nodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic in_word_t cell_at(input int col, input int row);
    in_word_t w;
    w.cell_col = col[CELL_W-1:0];
    w.cell_row = row[CELL_W-1:0];
    return w;
  endfunction

  // mostly cells inside the grid, some anywhere
  function automatic in_word_t pick_cell();
    int nx, ny;
    nx = (grid_across > MAX_CELLS) ? MAX_CELLS : int'(grid_across);
    ny = (grid_down > MAX_CELLS) ? MAX_CELLS : int'(grid_down);
    if (nx > 0 && ny > 0 && $urandom_range(0, 9) != 0) begin
      return cell_at($urandom_range(0, nx - 1), $urandom_range(0, ny - 1));
    end
    return cell_at($urandom_range(0, 1023), $urandom_range(0, 1023));
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 7))
      0: return 11'd1;
      1: return 11'd1024;
      2: return 11'($urandom_range(1025, 2047));
      3: return 11'($urandom_range(2, 1023));
      default: return 11'($urandom_range(1, 12));
    endcase
  endfunction

  // result checker and receiver stalls
  initial begin : result_side
    int stall_left;
    out_word_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready) begin
        if (expected_nodes.size() == 0) begin
          report_mismatch($sformatf("unexpected word, node_index %0d", out_word.node_index));
        end else begin
          want = expected_nodes.pop_front();
          if (out_word.node_index !== want.node_index)
            report_mismatch($sformatf("node_index got %0d want %0d",
                                      out_word.node_index, want.node_index));
          if (out_word.upper_half !== want.upper_half)
            report_mismatch($sformatf("upper_half got %0b want %0b",
                                      out_word.upper_half, want.upper_half));
          if (out_word.local_slot !== want.local_slot)
            report_mismatch($sformatf("local_slot got %0d want %0d",
                                      out_word.local_slot, want.local_slot));
          if (out_word.error !== want.error)
            report_mismatch($sformatf("error got %0b want %0b", out_word.error, want.error));
          if (out_word.last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", out_word.last, want.last));
        end
      end
      // ready for the next cycle
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ends the run when neither side moves for too long
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck = 0;
      else stuck++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // reset grid is one quadratic cell
  task automatic test_reset_defaults();
    offer_cell(cell_at(0, 0));
    offer_cell(cell_at(1, 0));
    offer_cell(cell_at(0, 1));
    offer_cell(cell_at(1023, 1023));
    finish_phase();
  endtask

  // corner cells of the largest grid
  task automatic test_full_grid(input logic order);
    program_grid(11'd1024, 11'd1024, order);
    offer_cell(cell_at(0, 0));
    offer_cell(cell_at(1023, 1023));
    offer_cell(cell_at(1023, 0));
    offer_cell(cell_at(0, 1023));
    finish_phase();
  endtask

  // zero counts and counts above the cell limit
  task automatic test_zero_and_clamp();
    program_grid(11'd2047, 11'd0, ORDER_QUAD);
    offer_cell(cell_at(0, 0));
    offer_cell(cell_at(1023, 0));
    finish_phase();
    program_grid(11'd0, 11'd3, ORDER_QUART);
    offer_cell(cell_at(0, 0));
    offer_cell(cell_at(0, 2));
    finish_phase();
    program_grid(11'd2047, 11'd1100, ORDER_QUART);
    offer_cell(cell_at(1023, 1023));
    offer_cell(cell_at(512, 1));
    offer_cell(cell_at(1, 700));
    finish_phase();
  endtask

  // random grids and cells, idling switched per phase
  task automatic test_random_grids();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      tx_gaps_on = $urandom_range(0, 3) != 0;
      rx_stalls_on = $urandom_range(0, 3) != 0;
      program_grid(pick_count(), pick_count(), 1'($urandom_range(0, 1)));
      repeat (20) offer_cell(pick_cell());
      finish_phase();
    end
  endtask

  // receiver holds off so the block backs up, then the sender waits for drain
  task automatic test_output_hold_off();
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    program_grid(11'd7, 11'd5, ORDER_QUART);
    hold_off_cycles = 300;
    repeat (10) offer_cell(pick_cell());
    in_valid <= 1'b0;
    while (expected_nodes.size() != 0) @(posedge clk);
    repeat (6) offer_cell(pick_cell());
    finish_phase();
  endtask

  // back-to-back cells with no idling on either side
  task automatic test_full_rate();
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    program_grid(11'd1024, 11'd1024, ORDER_QUAD);
    repeat (10) offer_cell(pick_cell());
    finish_phase();
    program_grid(11'($urandom_range(1, 40)), 11'($urandom_range(1, 40)), ORDER_QUART);
    repeat (10) offer_cell(pick_cell());
    finish_phase();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_full_grid(ORDER_QUAD);
    test_full_grid(ORDER_QUART);
    test_zero_and_clamp();
    test_random_grids();
    test_output_hold_off();
    test_full_rate();
    if (error_count == 0 && expected_nodes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
